>>> hdl/assert_macros.svh
// Assertion macros shared by the radix text calculator RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold on every clock edge.
`define RTC_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that must hold on the clock edge after a trigger.
`define RTC_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

>>> hdl/rtc_pkg.sv
// Package for the radix text calculator: word widths, codes and ASCII constants.
// It also holds the small decode functions used by the operand parser and top level.
// Depends on nothing.
`default_nettype none

package rtc_pkg;

	localparam int WORD_BITS  = 32;
	// Decimal digits of the largest word: floor(WORD_BITS * log10(2)) + 1.
	localparam int DEC_DIGITS = (WORD_BITS * 30103) / 100000 + 1;
	localparam int OCT_DIGITS = (WORD_BITS + 2) / 3;
	localparam int HEX_DIGITS = (WORD_BITS + 3) / 4;
	// The BCD image is the widest digit layout, so it sizes the digit register.
	localparam int DIG_W      = 4 * DEC_DIGITS;
	localparam int CNT_W      = $clog2(WORD_BITS + 1);

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 8;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	localparam logic [1:0] REQ_A    = 2'd0;
	localparam logic [1:0] REQ_B    = 2'd1;
	localparam logic [1:0] REQ_EXEC = 2'd2;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;

	localparam logic [1:0] RADIX_BIN = 2'd0;
	localparam logic [1:0] RADIX_OCT = 2'd1;
	localparam logic [1:0] RADIX_DEC = 2'd2;
	localparam logic [1:0] RADIX_HEX = 2'd3;

	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_LOWER_B = 8'h62;
	localparam logic [7:0] CH_LOWER_D = 8'h64;
	localparam logic [7:0] CH_LOWER_O = 8'h6F;
	localparam logic [7:0] CH_LOWER_X = 8'h78;

	typedef enum logic [1:0] {
		DOP_HOLD,
		DOP_LOAD,
		DOP_DABBLE,
		DOP_SHIFT
	} dig_op_t;

	typedef struct packed {
		dig_op_t    op;
		logic [1:0] radix;
	} dig_cmd_t;

	function automatic logic [4:0] radix_value(input logic [1:0] radix);
		logic [4:0] v;
		unique case (radix)
			RADIX_BIN: v = 5'd2;
			RADIX_OCT: v = 5'd8;
			RADIX_DEC: v = 5'd10;
			RADIX_HEX: v = 5'd16;
			default:   v = 5'd2;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] radix_letter(input logic [1:0] radix);
		logic [7:0] c;
		unique case (radix)
			RADIX_BIN: c = CH_LOWER_B;
			RADIX_OCT: c = CH_LOWER_O;
			RADIX_DEC: c = CH_LOWER_D;
			RADIX_HEX: c = CH_LOWER_X;
			default:   c = CH_LOWER_B;
		endcase
		return c;
	endfunction

	function automatic cnt_t digit_count(input logic [1:0] radix);
		cnt_t n;
		unique case (radix)
			RADIX_BIN: n = CNT_W'(WORD_BITS);
			RADIX_OCT: n = CNT_W'(OCT_DIGITS);
			RADIX_DEC: n = CNT_W'(DEC_DIGITS);
			RADIX_HEX: n = CNT_W'(HEX_DIGITS);
			default:   n = CNT_W'(WORD_BITS);
		endcase
		return n;
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'b0000, d};
		end else begin
			c = CH_UPPER_A + {4'b0000, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> hdl/rtc_operand.sv
// Operand text parser: sign, base letter and digit accumulation for one operand.
// Uses rtc_pkg for widths, radix codes and ASCII constants.
`default_nettype none

module rtc_operand (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           take,
	input  wire logic           clear,
	input  wire logic [7:0]     symbol,
	output rtc_pkg::word_t      value,
	output logic                bad
);

	typedef enum logic [1:0] {
		PH_SIGN,
		PH_LETTER,
		PH_DIGITS
	} phase_t;

	rtc_pkg::word_t acc_q;
	logic           neg_q;
	logic [1:0]     radix_q;
	phase_t         phase_q;

	logic           letter_ok;
	logic [1:0]     letter_code;
	logic           is_num;
	logic           is_hex;
	logic [7:0]     digit_raw;
	logic [3:0]     digit;
	logic           digit_ok;
	logic           sign_take;
	logic           in_prefix;
	rtc_pkg::word_t scaled;
	rtc_pkg::word_t acc_next;

	always_comb begin
		letter_ok   = 1'b1;
		letter_code = rtc_pkg::RADIX_BIN;
		unique case (symbol)
			rtc_pkg::CH_LOWER_B: letter_code = rtc_pkg::RADIX_BIN;
			rtc_pkg::CH_LOWER_O: letter_code = rtc_pkg::RADIX_OCT;
			rtc_pkg::CH_LOWER_D: letter_code = rtc_pkg::RADIX_DEC;
			rtc_pkg::CH_LOWER_X: letter_code = rtc_pkg::RADIX_HEX;
			default:             letter_ok   = 1'b0;
		endcase
	end

	assign is_num    = (symbol >= rtc_pkg::CH_ZERO) && (symbol <= rtc_pkg::CH_NINE);
	assign is_hex    = (symbol >= rtc_pkg::CH_UPPER_A) && (symbol <= rtc_pkg::CH_UPPER_F);
	assign digit_raw = is_num ? (symbol - rtc_pkg::CH_ZERO)
	                          : (symbol - rtc_pkg::CH_UPPER_A + 8'd10);
	assign digit     = digit_raw[3:0];
	assign digit_ok  = (is_num || is_hex) && ({1'b0, digit} < rtc_pkg::radix_value(radix_q));

	// Multiplying by the base is a shift, or two shifts and an add for decimal.
	always_comb begin
		unique case (radix_q)
			rtc_pkg::RADIX_BIN: scaled = acc_q << 1;
			rtc_pkg::RADIX_OCT: scaled = acc_q << 3;
			rtc_pkg::RADIX_DEC: scaled = (acc_q << 3) + (acc_q << 1);
			rtc_pkg::RADIX_HEX: scaled = acc_q << 4;
			default:            scaled = acc_q;
		endcase
	end

	assign acc_next  = scaled + rtc_pkg::WORD_BITS'(digit);
	assign sign_take = (phase_q == PH_SIGN) && (symbol == rtc_pkg::CH_MINUS);
	assign in_prefix = (phase_q != PH_DIGITS);
	assign bad       = take && (in_prefix ? (!sign_take && !letter_ok) : !digit_ok);
	assign value     = neg_q ? (rtc_pkg::word_t'(0) - acc_q) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			neg_q   <= 1'b0;
			radix_q <= rtc_pkg::RADIX_BIN;
			phase_q <= PH_SIGN;
		end else if (clear) begin
			acc_q   <= '0;
			neg_q   <= 1'b0;
			radix_q <= rtc_pkg::RADIX_BIN;
			phase_q <= PH_SIGN;
		end else if (take) begin
			if (sign_take) begin
				neg_q   <= 1'b1;
				phase_q <= PH_LETTER;
			end else if (in_prefix) begin
				if (letter_ok) begin
					radix_q <= letter_code;
					phase_q <= PH_DIGITS;
				end
			end else if (digit_ok) begin
				acc_q <= acc_next;
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/rtc_digit_unit.sv
// Shared digit shift unit: loads the result magnitude, converts it to BCD by
// shift-and-add-3, and shifts out one digit of the chosen radix per command.
// Uses rtc_pkg for widths, radix codes and the command struct.
`default_nettype none

module rtc_digit_unit (
	input  wire logic              clk,
	input  wire rtc_pkg::dig_cmd_t cmd,
	input  wire rtc_pkg::word_t    load_value,
	output logic [3:0]             top_digit
);

	logic [rtc_pkg::DIG_W-1:0] dig_q;
	rtc_pkg::word_t            bin_q;
	logic [1:0]                radix_q;
	logic [rtc_pkg::DIG_W-1:0] adj;
	logic [rtc_pkg::DIG_W-1:0] aligned;

	// Before each doubling, every BCD digit of five or more gets three added.
	always_comb begin
		logic [3:0] nib;
		adj = dig_q;
		for (int k = 0; k < rtc_pkg::DEC_DIGITS; k++) begin
			nib            = dig_q[4*k +: 4];
			adj[4*k +: 4]  = (nib >= 4'd5) ? (nib + 4'd3) : nib;
		end
	end

	// Power-of-two bases are placed so that the top digit sits in the top bits.
	always_comb begin
		unique case (cmd.radix)
			rtc_pkg::RADIX_BIN:
				aligned = rtc_pkg::DIG_W'(load_value) << (rtc_pkg::DIG_W - rtc_pkg::WORD_BITS);
			rtc_pkg::RADIX_OCT:
				aligned = rtc_pkg::DIG_W'(load_value)
					<< (rtc_pkg::DIG_W - 3 * rtc_pkg::OCT_DIGITS);
			rtc_pkg::RADIX_HEX:
				aligned = rtc_pkg::DIG_W'(load_value)
					<< (rtc_pkg::DIG_W - 4 * rtc_pkg::HEX_DIGITS);
			default:
				aligned = '0;
		endcase
	end

	// The digit width is taken from the radix latched at load, so the top digit
	// depends on registers only.
	always_comb begin
		case (radix_q) inside
			rtc_pkg::RADIX_BIN: top_digit = {3'b000, dig_q[rtc_pkg::DIG_W-1]};
			rtc_pkg::RADIX_OCT: top_digit = {1'b0, dig_q[rtc_pkg::DIG_W-1 -: 3]};
			rtc_pkg::RADIX_DEC, rtc_pkg::RADIX_HEX:
				top_digit = dig_q[rtc_pkg::DIG_W-1 -: 4];
			default:            top_digit = dig_q[rtc_pkg::DIG_W-1 -: 4];
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			rtc_pkg::DOP_HOLD: begin
			end
			rtc_pkg::DOP_LOAD: begin
				dig_q   <= aligned;
				bin_q   <= load_value;
				radix_q <= cmd.radix;
			end
			rtc_pkg::DOP_DABBLE: begin
				dig_q <= {adj[rtc_pkg::DIG_W-2:0], bin_q[rtc_pkg::WORD_BITS-1]};
				bin_q <= {bin_q[rtc_pkg::WORD_BITS-2:0], 1'b0};
			end
			rtc_pkg::DOP_SHIFT: begin
				case (cmd.radix) inside
					rtc_pkg::RADIX_BIN: dig_q <= dig_q << 1;
					rtc_pkg::RADIX_OCT: dig_q <= dig_q << 3;
					rtc_pkg::RADIX_DEC, rtc_pkg::RADIX_HEX: dig_q <= dig_q << 4;
					default:            dig_q <= dig_q << 4;
				endcase
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/radix_text_calculator.sv
// Top level of the radix text calculator: stream ports, sequencer and output register.
// Depends on rtc_pkg, rtc_operand, rtc_digit_unit and assert_macros.svh.
`default_nettype none

// Operand characters are taken at one word per cycle while the block is idle.
// An execute word makes the block busy until its last result character has
// been loaded into the output register: it computes and loads the result, then
// for a decimal result runs the binary-to-BCD conversion over every bit of the
// word, then drops the leading zero digits one by one and finds the first digit
// kept, then loads the output characters one by one while the sink takes them.
// All of this runs through the one digit shift register in rtc_digit_unit; a
// binary result is at most 33 characters. The output register lets the block
// take new operand characters while the final result character still waits
// for the sink.

`include "assert_macros.svh"

module radix_text_calculator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// Fields from bit 0 up: symbol[7:0], op[9:8], out_base[11:10], zero fill.
	input  wire logic [rtc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// Fields from bit 0 up: req_type[1:0].
	input  wire logic [1:0]                        s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// Fields from bit 0 up: out_char[7:0].
	output logic [rtc_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
	output logic                                   m_axis_tlast,
	// Fields from bit 0 up: error[0].
	output logic [0:0]                             m_axis_tuser
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_LOAD,
		ST_DABBLE,
		ST_SKIP,
		ST_LETTER,
		ST_SIGN,
		ST_DIGITS
	} state_t;

	state_t              state_q;
	rtc_pkg::cnt_t       cnt_q;
	logic                neg_q;
	logic                err_flag_q;
	logic                err_q;
	logic                out_valid_q;
	logic [7:0]          out_char_q;
	logic                out_last_q;
	logic                out_err_q;

	rtc_pkg::word_t      a_q;
	rtc_pkg::word_t      b_q;
	logic [1:0]          op_q;
	logic [1:0]          base_q;
	rtc_pkg::word_t      res_q;

	logic                in_fire;
	logic                take_a;
	logic                take_b;
	logic                exec;
	logic [7:0]          symbol;
	rtc_pkg::word_t      val_a;
	rtc_pkg::word_t      val_b;
	logic                bad_a;
	logic                bad_b;
	rtc_pkg::word_t      prod;
	rtc_pkg::word_t      calc;
	logic                res_neg;
	rtc_pkg::word_t      mag;
	rtc_pkg::dig_cmd_t   cmd;
	logic [3:0]          top_digit;
	logic                cnt_one;
	logic                out_free;
	logic                out_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign symbol        = s_axis_tdata[7:0];
	assign take_a        = in_fire && (s_axis_tuser == rtc_pkg::REQ_A);
	assign take_b        = in_fire && (s_axis_tuser == rtc_pkg::REQ_B);
	assign exec          = in_fire && (s_axis_tuser == rtc_pkg::REQ_EXEC);

	rtc_operand u_operand_a (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take_a),
		.clear  (exec),
		.symbol (symbol),
		.value  (val_a),
		.bad    (bad_a)
	);

	rtc_operand u_operand_b (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take_b),
		.clear  (exec),
		.symbol (symbol),
		.value  (val_b),
		.bad    (bad_b)
	);

	assign prod = a_q * b_q;

	always_comb begin
		unique case (op_q)
			rtc_pkg::OP_ADD: calc = a_q + b_q;
			rtc_pkg::OP_SUB: calc = a_q - b_q;
			rtc_pkg::OP_MUL: calc = prod;
			default:         calc = '0;
		endcase
	end

	// Binary prints the raw two's complement pattern; other bases print a sign.
	assign res_neg = res_q[rtc_pkg::WORD_BITS-1] && (base_q != rtc_pkg::RADIX_BIN);
	assign mag     = res_neg ? (rtc_pkg::word_t'(0) - res_q) : res_q;

	assign cnt_one  = (cnt_q == rtc_pkg::CNT_W'(1));
	assign out_free = !out_valid_q || m_axis_tready;
	assign out_load = out_free &&
		(state_q == ST_LETTER || state_q == ST_SIGN || state_q == ST_DIGITS);

	always_comb begin
		cmd.radix = base_q;
		cmd.op    = rtc_pkg::DOP_HOLD;
		unique case (state_q)
			ST_LOAD:   cmd.op = rtc_pkg::DOP_LOAD;
			ST_DABBLE: cmd.op = rtc_pkg::DOP_DABBLE;
			ST_SKIP: begin
				if (top_digit == 4'd0 && !cnt_one) begin
					cmd.op = rtc_pkg::DOP_SHIFT;
				end
			end
			ST_DIGITS: begin
				if (out_free) begin
					cmd.op = rtc_pkg::DOP_SHIFT;
				end
			end
			default:   cmd.op = rtc_pkg::DOP_HOLD;
		endcase
	end

	rtc_digit_unit u_digit_unit (
		.clk        (clk),
		.cmd        (cmd),
		.load_value (mag),
		.top_digit  (top_digit)
	);

	always_ff @(posedge clk) begin
		if (exec) begin
			a_q    <= val_a;
			b_q    <= val_b;
			op_q   <= s_axis_tdata[9:8];
			base_q <= s_axis_tdata[11:10];
		end
		if (state_q == ST_CALC) begin
			res_q <= calc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			neg_q       <= 1'b0;
			err_flag_q  <= 1'b0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_char_q  <= '0;
			out_last_q  <= 1'b0;
			out_err_q   <= 1'b0;
		end else begin
			if (m_axis_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end

			if (exec) begin
				err_flag_q <= 1'b0;
			end else if (bad_a || bad_b) begin
				err_flag_q <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (exec) begin
						err_q   <= err_flag_q;
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					neg_q <= res_neg;
					if (base_q == rtc_pkg::RADIX_DEC) begin
						cnt_q   <= rtc_pkg::CNT_W'(rtc_pkg::WORD_BITS);
						state_q <= ST_DABBLE;
					end else begin
						cnt_q   <= rtc_pkg::digit_count(base_q);
						state_q <= ST_SKIP;
					end
				end
				ST_DABBLE: begin
					if (cnt_one) begin
						cnt_q   <= rtc_pkg::digit_count(rtc_pkg::RADIX_DEC);
						state_q <= ST_SKIP;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SKIP: begin
					// Leading zero digits are dropped, but the last digit always stays.
					if (top_digit == 4'd0 && !cnt_one) begin
						cnt_q <= cnt_q - 1'b1;
					end else begin
						state_q <= ST_LETTER;
					end
				end
				ST_LETTER: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= rtc_pkg::radix_letter(base_q);
						out_last_q  <= 1'b0;
						out_err_q   <= err_q;
						state_q     <= neg_q ? ST_SIGN : ST_DIGITS;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= rtc_pkg::CH_MINUS;
						out_last_q  <= 1'b0;
						out_err_q   <= err_q;
						state_q     <= ST_DIGITS;
					end
				end
				ST_DIGITS: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_char_q  <= rtc_pkg::digit_char(top_digit);
						out_last_q  <= cnt_one;
						out_err_q   <= err_q;
						if (cnt_one) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_err_q;

	`RTC_ASSERT_NEXT(a_exec_goes_busy, exec, !s_axis_tready,
		"execute word did not make the block busy")
	`RTC_ASSERT_ALWAYS(a_count_live,
		!(state_q == ST_DABBLE || state_q == ST_SKIP || state_q == ST_DIGITS) || cnt_q != '0,
		"digit counter reached zero inside the conversion")
	`RTC_ASSERT_ALWAYS(a_no_stale_last,
		!(m_axis_tvalid && m_axis_tlast) || (state_q != ST_SIGN && state_q != ST_DIGITS),
		"last character still shown after a newer result started")

endmodule

`default_nettype wire

>>> verif/radix_text_calculator_tb.sv
// Self-checking testbench for radix_text_calculator: drives operand text and
// execute words, predicts the result text and checks every output word.
// Depends on rtc_pkg and the radix_text_calculator RTL.
`default_nettype none

module radix_text_calculator_tb;

	// Request and operation codes that the package leaves unnamed.
	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam logic [1:0] OP_NONE  = 2'd3;

	typedef enum logic [1:0] {
		EXPECT_SIGN,
		EXPECT_LETTER,
		EXPECT_DIGITS
	} parse_phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       err;
	} text_char_t;

	typedef logic [7:0] char_q_t[$];

	class calc_text_board;
		rtc_pkg::word_t acc[2];
		logic           neg[2];
		logic [1:0]     radix[2];
		parse_phase_t   phase[2];
		logic           err_seen;
		text_char_t     pending_text[$];
		int             fails;

		function new();
			fails = 0;
			clear_operands();
		endfunction

		static function rtc_pkg::word_t radix_weight(logic [1:0] r);
			case (r)
				rtc_pkg::RADIX_BIN: return 2;
				rtc_pkg::RADIX_OCT: return 8;
				rtc_pkg::RADIX_DEC: return 10;
				default:            return 16;
			endcase
		endfunction

		static function logic [7:0] radix_mark(logic [1:0] r);
			case (r)
				rtc_pkg::RADIX_BIN: return rtc_pkg::CH_LOWER_B;
				rtc_pkg::RADIX_OCT: return rtc_pkg::CH_LOWER_O;
				rtc_pkg::RADIX_DEC: return rtc_pkg::CH_LOWER_D;
				default:            return rtc_pkg::CH_LOWER_X;
			endcase
		endfunction

		static function logic [7:0] digit_glyph(rtc_pkg::word_t d);
			if (d < 10) begin
				return rtc_pkg::CH_ZERO + 8'(d);
			end
			return rtc_pkg::CH_UPPER_A + 8'(d - 10);
		endfunction

		function void clear_operands();
			for (int s = 0; s < 2; s++) begin
				acc[s]   = '0;
				neg[s]   = 1'b0;
				radix[s] = rtc_pkg::RADIX_BIN;
				phase[s] = EXPECT_SIGN;
			end
			err_seen = 1'b0;
		endfunction

		function void parse_char(int s, logic [7:0] ch);
			rtc_pkg::word_t d;
			if (phase[s] == EXPECT_SIGN && ch == rtc_pkg::CH_MINUS) begin
				neg[s]   = 1'b1;
				phase[s] = EXPECT_LETTER;
				return;
			end
			if (phase[s] != EXPECT_DIGITS) begin
				case (ch)
					rtc_pkg::CH_LOWER_B: radix[s] = rtc_pkg::RADIX_BIN;
					rtc_pkg::CH_LOWER_O: radix[s] = rtc_pkg::RADIX_OCT;
					rtc_pkg::CH_LOWER_D: radix[s] = rtc_pkg::RADIX_DEC;
					rtc_pkg::CH_LOWER_X: radix[s] = rtc_pkg::RADIX_HEX;
					default: begin
						err_seen = 1'b1;
						return;
					end
				endcase
				phase[s] = EXPECT_DIGITS;
				return;
			end
			if (ch >= rtc_pkg::CH_ZERO && ch <= rtc_pkg::CH_NINE) begin
				d = rtc_pkg::word_t'(ch - rtc_pkg::CH_ZERO);
			end else if (ch >= rtc_pkg::CH_UPPER_A && ch <= rtc_pkg::CH_UPPER_F) begin
				d = rtc_pkg::word_t'(ch - rtc_pkg::CH_UPPER_A) + 10;
			end else begin
				err_seen = 1'b1;
				return;
			end
			if (d >= radix_weight(radix[s])) begin
				err_seen = 1'b1;
				return;
			end
			acc[s] = acc[s] * radix_weight(radix[s]) + d;
		endfunction

		function void take_word(logic [1:0] req, logic [7:0] ch, logic [1:0] op,
				logic [1:0] base);
			rtc_pkg::word_t a;
			rtc_pkg::word_t b;
			rtc_pkg::word_t r;
			rtc_pkg::word_t w;
			logic           e;
			logic [7:0]     glyphs[$];
			if (req == rtc_pkg::REQ_A) begin
				parse_char(0, ch);
				return;
			end
			if (req == rtc_pkg::REQ_B) begin
				parse_char(1, ch);
				return;
			end
			if (req != rtc_pkg::REQ_EXEC) begin
				return;
			end
			a = neg[0] ? -acc[0] : acc[0];
			b = neg[1] ? -acc[1] : acc[1];
			case (op)
				rtc_pkg::OP_ADD: r = a + b;
				rtc_pkg::OP_SUB: r = a - b;
				rtc_pkg::OP_MUL: r = a * b;
				default:         r = '0;
			endcase
			e = err_seen;
			clear_operands();
			pending_text.push_back('{radix_mark(base), 1'b0, e});
			// Binary shows the raw two's complement pattern, the others a sign.
			if (r[rtc_pkg::WORD_BITS-1] && base != rtc_pkg::RADIX_BIN) begin
				pending_text.push_back('{rtc_pkg::CH_MINUS, 1'b0, e});
				r = -r;
			end
			w = radix_weight(base);
			do begin
				glyphs.push_front(digit_glyph(r % w));
				r = r / w;
			end while (r != 0);
			foreach (glyphs[i]) begin
				pending_text.push_back('{glyphs[i], i == glyphs.size() - 1, e});
			end
		endfunction

		function void check_char(logic [7:0] ch, logic last, logic err);
			text_char_t want;
			if (pending_text.size() == 0) begin
				$error("output word %h with no result text pending", ch);
				fails++;
				return;
			end
			want = pending_text.pop_front();
			if (ch !== want.ch) begin
				$error("out_char expected %h actual %h", want.ch, ch);
				fails++;
			end
			if (last !== want.last) begin
				$error("last expected %b actual %b", want.last, last);
				fails++;
			end
			if (err !== want.err) begin
				$error("error expected %b actual %b", want.err, err);
				fails++;
			end
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [rtc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [1:0]                      s_axis_tuser = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [rtc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                            m_axis_tlast;
	logic [0:0]                      m_axis_tuser;

	calc_text_board board = new();
	bit             gaps_on = 1'b1;
	int             sink_hold = 0;
	int             words_sent = 0;

	radix_text_calculator i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Sink: check the word taken at this edge, then pick tready for the next one.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			board.check_char(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
		end
		if (sink_hold > 0) begin
			m_axis_tready <= 1'b0;
			sink_hold--;
		end else if (gaps_on && $urandom_range(0, 4) == 0) begin
			m_axis_tready <= 1'b0;
			sink_hold = $urandom_range(0, 2);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic send_word(logic [1:0] req, logic [7:0] ch, logic [1:0] op,
			logic [1:0] base);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0000, base, op, ch};
		s_axis_tuser  <= req;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		board.take_word(req, ch, op, base);
		if (req != REQ_NONE) begin
			words_sent++;
		end
	endtask

	task automatic send_text(logic [1:0] req, string s);
		for (int i = 0; i < s.len(); i++) begin
			send_word(req, s[i], 2'($urandom), 2'($urandom));
		end
	endtask

	task automatic execute(logic [1:0] op, logic [1:0] base);
		send_word(rtc_pkg::REQ_EXEC, 8'($urandom), op, base);
	endtask

	function automatic char_q_t build_operand();
		char_q_t        t;
		logic [1:0]     r;
		rtc_pkg::word_t w;
		rtc_pkg::word_t v;
		int             mode;
		int             len;
		int             longest;
		if ($urandom_range(0, 2) == 0) begin
			t.push_back(rtc_pkg::CH_MINUS);
		end
		r = 2'($urandom);
		w = calc_text_board::radix_weight(r);
		// Now and then the base letter is missing, so the digits are rejected.
		if ($urandom_range(0, 11) != 0) begin
			t.push_back(calc_text_board::radix_mark(r));
		end
		mode = $urandom_range(0, 9);
		if (mode <= 5) begin
			len = $urandom_range(1, 4);
			repeat (len) t.push_back(calc_text_board::digit_glyph($urandom % w));
		end else if (mode <= 7) begin
			// Long strings, some past the word width so the accumulator wraps.
			case (r)
				rtc_pkg::RADIX_BIN: longest = 34;
				rtc_pkg::RADIX_OCT: longest = 12;
				rtc_pkg::RADIX_DEC: longest = 11;
				default:            longest = 9;
			endcase
			len = $urandom_range(5, longest);
			repeat (len) t.push_back(calc_text_board::digit_glyph($urandom % w));
		end else begin
			case ($urandom_range(0, 5))
				0:       v = '0;
				1:       v = 1;
				2:       v = 32'h7FFF_FFFF;
				3:       v = 32'h8000_0000;
				4:       v = 32'hFFFF_FFFF;
				default: v = $urandom;
			endcase
			len = t.size();
			do begin
				t.insert(len, calc_text_board::digit_glyph(v % w));
				v = v / w;
			end while (v != 0);
		end
		if ($urandom_range(0, 9) == 0) begin
			t.insert($urandom_range(0, t.size()), 8'($urandom));
		end
		return t;
	endfunction

	task automatic random_calc();
		char_q_t    ta;
		char_q_t    tb;
		logic [1:0] op;
		ta = build_operand();
		tb = build_operand();
		while (ta.size() + tb.size() > 0) begin
			if (tb.size() == 0 || (ta.size() > 0 && $urandom_range(0, 1) == 0)) begin
				send_word(rtc_pkg::REQ_A, ta.pop_front(), 2'($urandom), 2'($urandom));
			end else begin
				send_word(rtc_pkg::REQ_B, tb.pop_front(), 2'($urandom), 2'($urandom));
			end
		end
		op = ($urandom_range(0, 9) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
		execute(op, 2'($urandom));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero result straight out of reset.
		execute(rtc_pkg::OP_ADD, rtc_pkg::RADIX_BIN);
		// Negative decimal result with a signed first operand.
		send_text(rtc_pkg::REQ_A, "-d9");
		send_text(rtc_pkg::REQ_B, "xF");
		execute(rtc_pkg::OP_SUB, rtc_pkg::RADIX_DEC);
		// Digit not below the base, lowercase digit, and a second sign.
		send_text(rtc_pkg::REQ_A, "o8a7");
		send_text(rtc_pkg::REQ_B, "--b1");
		execute(rtc_pkg::OP_MUL, rtc_pkg::RADIX_HEX);
		// Sign after the base letter, and the unused operation code.
		send_text(rtc_pkg::REQ_A, "x-F");
		execute(OP_NONE, rtc_pkg::RADIX_OCT);
		send_word(REQ_NONE, 8'($urandom), 2'($urandom), 2'($urandom));
		// Operand A never got a base letter and counts as zero.
		send_text(rtc_pkg::REQ_B, "d2");
		execute(rtc_pkg::OP_ADD, rtc_pkg::RADIX_OCT);
		// Negative binary result prints the full word.
		send_text(rtc_pkg::REQ_B, "b1");
		execute(rtc_pkg::OP_SUB, rtc_pkg::RADIX_BIN);

		while (words_sent < 310) begin
			if (words_sent > 250) begin
				gaps_on = 1'b0;
			end
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 6)) begin
					send_word(2'($urandom), 8'($urandom), 2'($urandom), 2'($urandom));
				end
			end else begin
				random_calc();
			end
		end
		s_axis_tvalid <= 1'b0;

		while (board.pending_text.size() != 0) begin
			@(posedge clk);
		end
		repeat (80) @(posedge clk);
		if (board.pending_text.size() != 0) begin
			$error("%0d result words never arrived", board.pending_text.size());
			board.fails++;
		end
		if (board.fails == 0) begin
			$display("radix_text_calculator verification clean");
		end else begin
			$display("radix_text_calculator verification failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("radix_text_calculator verification failed");
		$finish;
	end

endmodule

`default_nettype wire
